### hdl/zcbpc_pkg.sv
// ----------------------------------------------------------------------------
// zcbpc_pkg
// shared widths, event codes and constants of the burst-fire power controller
// ----------------------------------------------------------------------------
package zcbpc_pkg;

    localparam int KIND_W    = 2;
    localparam int TICK_W    = 32;
    localparam int PCT_W     = 7;
    localparam int COUNT_W   = 8;
    localparam int ERR_W     = 9;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CROSSING = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SETTING  = 2'd2;

    localparam logic [0:0] REG_TICKS_PER_WINDOW = 1'b0;

    localparam logic [TICK_W-1:0]  TPW_RESET    = 32'd1000;
    localparam logic [COUNT_W-1:0] PRESENT_LOW  = 8'd95;
    localparam logic [COUNT_W-1:0] PRESENT_HIGH = 8'd105;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [PCT_W-1:0]   SETTING_MAX  = 7'd100;
    localparam logic signed [ERR_W-1:0] FIRE_LEVEL = 9'sd50;
    localparam logic signed [ERR_W-1:0] FIRE_STEP  = 9'sd100;

    typedef struct packed {
        logic                drive_primary;
        logic                drive_secondary;
        logic                power_present;
        logic [COUNT_W-1:0]  last_window_count;
    } result_t;

endpackage

### hdl/zcbpc_intf.sv
// ----------------------------------------------------------------------------
// zcbpc channel interfaces
// valid/ready channels for event words in and result words out
// ----------------------------------------------------------------------------
interface zcbpc_in_if;
    logic                             valid;
    logic                             ready;
    logic [zcbpc_pkg::KIND_W-1:0]     kind;
    logic [zcbpc_pkg::TICK_W-1:0]     now_ticks;
    logic [zcbpc_pkg::PCT_W-1:0]      power_percent;

    modport source (output valid, output kind, output now_ticks, output power_percent,
                    input ready);
    modport sink   (input valid, input kind, input now_ticks, input power_percent,
                    output ready);
endinterface

interface zcbpc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             drive_primary;
    logic                             drive_secondary;
    logic                             power_present;
    logic [zcbpc_pkg::COUNT_W-1:0]    last_window_count;

    modport source (output valid, output drive_primary, output drive_secondary,
                    output power_present, output last_window_count, input ready);
    modport sink   (input valid, input drive_primary, input drive_secondary,
                    input power_present, input last_window_count, output ready);
endinterface

### hdl/zero_cross_burst_power_control.sv
// ----------------------------------------------------------------------------
// zero_cross_burst_power_control
// burst-fire mains heater controller with mains presence detection
// ----------------------------------------------------------------------------
// Takes one event word per clock cycle when the output is not stalled (tick,
// zero crossing or power setting) and returns exactly one result word for each,
// in the cycle after acceptance, from a single output register. The whole state
// update is one short add and compare pass, so the input stays ready whenever the
// output register is empty or being taken in the same cycle; a stalled output
// holds the input back. The window length register sits at byte address 0 of the
// APB port and may only be written while no word is in flight.
// ----------------------------------------------------------------------------
module zero_cross_burst_power_control
(
    input  logic                              clk,
    input  logic                              rst_n,
    zcbpc_in_if.sink                          in_ch,
    zcbpc_out_if.source                       out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zcbpc_pkg::APB_AW-1:0]      paddr,
    input  logic [zcbpc_pkg::APB_DW-1:0]      pwdata,
    output logic [zcbpc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    logic [zcbpc_pkg::TICK_W-1:0]         tpw_reg;
    logic [zcbpc_pkg::TICK_W-1:0]         window_start_reg, window_start_next;
    logic [zcbpc_pkg::COUNT_W-1:0]        crossing_count_reg, crossing_count_next;
    logic                                 parity_reg, parity_next;
    logic                                 present_reg, present_next;
    logic [zcbpc_pkg::COUNT_W-1:0]        saved_count_reg, saved_count_next;
    logic signed [zcbpc_pkg::ERR_W-1:0]   error_sum_reg, error_sum_next;
    logic [zcbpc_pkg::PCT_W-1:0]          setting_reg, setting_next;
    logic [1:0]                           drive_reg, drive_next;
    logic                                 out_valid_reg;
    zcbpc_pkg::result_t                   result_reg, result_next;

    logic                                 in_accept;
    logic [zcbpc_pkg::TICK_W:0]           window_end;
    logic signed [zcbpc_pkg::ERR_W-1:0]   error_add;

    // configuration port
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == zcbpc_pkg::REG_TICKS_PER_WINDOW)
        begin
            prdata = tpw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpw_reg <= zcbpc_pkg::TPW_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == zcbpc_pkg::REG_TICKS_PER_WINDOW)
        begin
            tpw_reg <= pwdata;
        end
    end

    // handshake
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign window_end = {1'b0, window_start_reg} + {1'b0, tpw_reg};
    assign error_add  = error_sum_reg + $signed({2'b00, setting_reg});

    always_comb
    begin
        window_start_next   = window_start_reg;
        crossing_count_next = crossing_count_reg;
        parity_next         = parity_reg;
        present_next        = present_reg;
        saved_count_next    = saved_count_reg;
        error_sum_next      = error_sum_reg;
        setting_next        = setting_reg;
        drive_next          = drive_reg;

        case (in_ch.kind)
            zcbpc_pkg::KIND_TICK:
            begin
                if (window_end < {1'b0, in_ch.now_ticks})
                begin
                    window_start_next = in_ch.now_ticks;
                    if (crossing_count_reg > zcbpc_pkg::PRESENT_LOW
                        && crossing_count_reg < zcbpc_pkg::PRESENT_HIGH)
                    begin
                        present_next = 1'b1;
                    end
                    else
                    begin
                        present_next = 1'b0;
                        drive_next   = 2'b00;
                    end
                    saved_count_next    = crossing_count_reg;
                    crossing_count_next = '0;
                    parity_next         = 1'b0;
                end
            end
            zcbpc_pkg::KIND_CROSSING:
            begin
                if (crossing_count_reg != zcbpc_pkg::COUNT_MAX)
                begin
                    crossing_count_next = crossing_count_reg + 1'b1;
                end
                parity_next = !parity_reg;
                if (!parity_reg)
                begin
                    if (error_add >= zcbpc_pkg::FIRE_LEVEL)
                    begin
                        drive_next     = 2'b01;
                        error_sum_next = error_add - zcbpc_pkg::FIRE_STEP;
                    end
                    else
                    begin
                        drive_next     = 2'b10;
                        error_sum_next = error_add;
                    end
                end
            end
            zcbpc_pkg::KIND_SETTING:
            begin
                setting_next = (in_ch.power_percent > zcbpc_pkg::SETTING_MAX)
                             ? zcbpc_pkg::SETTING_MAX : in_ch.power_percent;
            end
            default:
            begin
            end
        endcase

        result_next.drive_primary     = drive_next[0];
        result_next.drive_secondary   = drive_next[1];
        result_next.power_present     = present_next;
        result_next.last_window_count = saved_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg   <= '0;
            crossing_count_reg <= '0;
            parity_reg         <= 1'b0;
            present_reg        <= 1'b0;
            saved_count_reg    <= '0;
            error_sum_reg      <= '0;
            setting_reg        <= '0;
            drive_reg          <= 2'b00;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                window_start_reg   <= window_start_next;
                crossing_count_reg <= crossing_count_next;
                parity_reg         <= parity_next;
                present_reg        <= present_next;
                saved_count_reg    <= saved_count_next;
                error_sum_reg      <= error_sum_next;
                setting_reg        <= setting_next;
                drive_reg          <= drive_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.drive_primary     = result_reg.drive_primary;
    assign out_ch.drive_secondary   = result_reg.drive_secondary;
    assign out_ch.power_present     = result_reg.power_present;
    assign out_ch.last_window_count = result_reg.last_window_count;

endmodule

### hdl/zcbpc_checker.sv
// ----------------------------------------------------------------------------
// zcbpc_checker
// port-level checks of the burst-fire power controller, bound to the top level
// ----------------------------------------------------------------------------
module zcbpc_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic out_valid,
    input  logic out_ready,
    input  logic drive_primary,
    input  logic drive_secondary
);

    // word stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // an accepted word yields a result word next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word gave no result word");

    // empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // drives never both on
    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_primary && drive_secondary))
        else $error("both drives on");

endmodule

bind zero_cross_burst_power_control zcbpc_checker u_zcbpc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .drive_primary   (out_ch.drive_primary),
    .drive_secondary (out_ch.drive_secondary)
);
